// ===== rtl/core/rhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsv_pkg
// shared constants for the premultiplied rgb to hsv converter
// ----------------------------------------------------------------------------
package rhsv_pkg;

    localparam int COMPONENT_BITS_DEF    = 16;
    localparam int HUE_FRACTION_BITS_DEF = 6;

    // hue sector bases and slope, in whole degrees
    localparam int HUE_BASE_RED   = 360;
    localparam int HUE_BASE_GREEN = 120;
    localparam int HUE_BASE_BLUE  = 240;
    localparam int HUE_SLOPE      = 60;
    localparam int HUE_TURN       = 360;

    // which component is the maximum
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

endpackage

// ===== rtl/core/rhsv_div.sv =====
// ----------------------------------------------------------------------------
// rhsv_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module rhsv_div #(
    parameter int QW = 16,
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [QW+DW-1:0]   num,
    input  logic [DW-1:0]      den,
    input  logic [SW-1:0]      side,
    output logic               out_valid,
    output logic [QW-1:0]      quo,
    output logic [SW-1:0]      side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] valid_reg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_prev;
        logic [QW-1:0] low_prev;
        logic [QW-1:0] q_prev;
        logic [DW-1:0] den_prev;
        logic [SW-1:0] side_prev;
        logic          valid_prev;
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (k == 0) begin : g_first
            // upper numerator bits are already below the divisor
            assign rem_prev   = num[QW+DW-1:QW];
            assign low_prev   = num[QW-1:0];
            assign q_prev     = '0;
            assign den_prev   = den;
            assign side_prev  = side;
            assign valid_prev = in_valid;
        end
        else begin : g_next
            assign rem_prev   = rem_reg[k-1];
            assign low_prev   = low_reg[k-1];
            assign q_prev     = q_reg[k-1];
            assign den_prev   = den_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_prev, low_prev[QW-1]};
            diff     = {1'b0, trial} - {2'b00, den_prev};
            ge       = ~diff[DW+1];
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            q_next   = (q_prev << 1) | QW'(ge);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_prev << 1;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// ===== rtl/core/rgb_to_hsv_premultiplied.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_premultiplied
// premultiplied rgba pixel to hue, saturation, brightness and straight alpha
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | premul_red premul_green premul_blue
//          |                      | pixel_alpha
//  out     | out_valid / out_stall| hue_sixtyfourths sat_out brightness_out
//          |                      | alpha_out
//
//  one pixel per cycle sustained while no held result stalls the pipe; a pixel
//  passes stage 0, the colour dividers, stages 1 to 3, the hue and saturation
//  dividers and the output stage, most of it one-bit divider stages
//  reset clears only the valid bits; payload registers are left alone
//  out_stall with a result waiting freezes every stage; in_stall follows it
// ----------------------------------------------------------------------------
module rgb_to_hsv_premultiplied #(
    parameter int COMPONENT_BITS    = rhsv_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rhsv_pkg::HUE_FRACTION_BITS_DEF,
    parameter int HUE_BITS          = $clog2(rhsv_pkg::HUE_TURN << HUE_FRACTION_BITS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [COMPONENT_BITS-1:0] premul_red,
    input  logic [COMPONENT_BITS-1:0] premul_green,
    input  logic [COMPONENT_BITS-1:0] premul_blue,
    input  logic [COMPONENT_BITS-1:0] pixel_alpha,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [HUE_BITS-1:0]       hue_sixtyfourths,
    output logic [COMPONENT_BITS-1:0] sat_out,
    output logic [COMPONENT_BITS-1:0] brightness_out,
    output logic [COMPONENT_BITS-1:0] alpha_out
);

    localparam int W    = COMPONENT_BITS;
    localparam int F    = HUE_FRACTION_BITS;
    // hue quotient before the wrap reaches 420 degrees
    localparam int HQW  = $clog2(421 << F);
    localparam int LQW  = (HQW > W) ? HQW : W;
    localparam int NUMW = W + 9;
    localparam int NHW  = LQW + W + 1;
    localparam logic [W-1:0]   MAXV     = '1;
    localparam logic [LQW-1:0] HUE_FULL = LQW'(rhsv_pkg::HUE_TURN << F);

    logic out_valid_reg;

    // global advance: the whole pipe moves unless a result is held
    logic en;
    assign en       = ~(out_valid_reg & out_stall);
    assign in_stall = ~en;

    // ---------------- stage 0: input capture
    logic         s0_valid_reg;
    logic [W-1:0] s0_r_reg, s0_g_reg, s0_b_reg, s0_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_r_reg <= premul_red;
            s0_g_reg <= premul_green;
            s0_b_reg <= premul_blue;
            s0_a_reg <= pixel_alpha;
        end
    end

    // ---------------- unpremultiply: (2*p*MAXV + a) / (2*a), three dividers
    logic [2*W-1:0] pm_r, pm_g, pm_b;
    logic [2*W:0]   nr, ng, nb;
    logic [W:0]     den_a;
    logic           sat_r, sat_g, sat_b;

    always_comb
    begin
        pm_r  = {s0_r_reg, {W{1'b0}}} - {{W{1'b0}}, s0_r_reg};
        pm_g  = {s0_g_reg, {W{1'b0}}} - {{W{1'b0}}, s0_g_reg};
        pm_b  = {s0_b_reg, {W{1'b0}}} - {{W{1'b0}}, s0_b_reg};
        nr    = {pm_r, 1'b0} + {{(W+1){1'b0}}, s0_a_reg};
        ng    = {pm_g, 1'b0} + {{(W+1){1'b0}}, s0_a_reg};
        nb    = {pm_b, 1'b0} + {{(W+1){1'b0}}, s0_a_reg};
        den_a = {s0_a_reg, 1'b0};
        // colour at or above alpha clips to 1.0
        sat_r = s0_r_reg >= s0_a_reg;
        sat_g = s0_g_reg >= s0_a_reg;
        sat_b = s0_b_reg >= s0_a_reg;
    end

    logic         du_valid;
    logic [W-1:0] qr, qg, qb;
    logic [W:0]   du_side;
    logic         du_sat_g, du_sat_b;

    rhsv_div #(.QW(W), .DW(W+1), .SW(W+1)) u_div_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .num       (nr),
        .den       (den_a),
        .side      ({s0_a_reg, sat_r}),
        .out_valid (du_valid),
        .quo       (qr),
        .side_out  (du_side)
    );

    rhsv_div #(.QW(W), .DW(W+1), .SW(1)) u_div_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .num       (ng),
        .den       (den_a),
        .side      (sat_g),
        .out_valid (),
        .quo       (qg),
        .side_out  (du_sat_g)
    );

    rhsv_div #(.QW(W), .DW(W+1), .SW(1)) u_div_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .num       (nb),
        .den       (den_a),
        .side      (sat_b),
        .out_valid (),
        .quo       (qb),
        .side_out  (du_sat_b)
    );

    // ---------------- stage 1: straight colour with clipping
    logic         s1_valid_reg;
    logic [W-1:0] s1_r_reg, s1_g_reg, s1_b_reg, s1_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= du_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg <= du_side[0] ? MAXV : qr;
            s1_g_reg <= du_sat_g   ? MAXV : qg;
            s1_b_reg <= du_sat_b   ? MAXV : qb;
            s1_a_reg <= du_side[W:1];
        end
    end

    // ---------------- stage 2: max, min, delta and sector
    rhsv_pkg::max_sel_t sel_next;
    logic [W-1:0]       max_next, min_next;
    logic signed [W:0]  n_next;

    always_comb
    begin
        // ties go to red, then green
        if (s1_r_reg >= s1_g_reg && s1_r_reg >= s1_b_reg)
        begin
            sel_next = rhsv_pkg::SEL_RED;
            max_next = s1_r_reg;
            n_next   = $signed({1'b0, s1_g_reg}) - $signed({1'b0, s1_b_reg});
        end
        else if (s1_g_reg >= s1_b_reg)
        begin
            sel_next = rhsv_pkg::SEL_GREEN;
            max_next = s1_g_reg;
            n_next   = $signed({1'b0, s1_b_reg}) - $signed({1'b0, s1_r_reg});
        end
        else
        begin
            sel_next = rhsv_pkg::SEL_BLUE;
            max_next = s1_b_reg;
            n_next   = $signed({1'b0, s1_r_reg}) - $signed({1'b0, s1_g_reg});
        end
        min_next = s1_r_reg;
        if (s1_g_reg < min_next)
        begin
            min_next = s1_g_reg;
        end
        if (s1_b_reg < min_next)
        begin
            min_next = s1_b_reg;
        end
    end

    logic               s2_valid_reg;
    rhsv_pkg::max_sel_t s2_sel_reg;
    logic [W-1:0]       s2_max_reg, s2_d_reg, s2_a_reg;
    logic signed [W:0]  s2_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sel_reg <= sel_next;
            s2_max_reg <= max_next;
            s2_d_reg   <= max_next - min_next;
            s2_n_reg   <= n_next;
            s2_a_reg   <= s1_a_reg;
        end
    end

    // ---------------- stage 3: hue and saturation numerators
    logic [8:0]          base_val;
    logic [NUMW-1:0]     bd;
    logic signed [NUMW:0] n_ext, n60, num_s;
    logic [NHW-1:0]      nh, ns;
    logic [2*W-1:0]      dm;
    logic [W:0]          den_h, den_s;
    logic                dzero;

    always_comb
    begin
        case (s2_sel_reg)
            rhsv_pkg::SEL_RED:   base_val = 9'(rhsv_pkg::HUE_BASE_RED);
            rhsv_pkg::SEL_GREEN: base_val = 9'(rhsv_pkg::HUE_BASE_GREEN);
            rhsv_pkg::SEL_BLUE:  base_val = 9'(rhsv_pkg::HUE_BASE_BLUE);
            default:             base_val = 9'(rhsv_pkg::HUE_BASE_RED);
        endcase
        bd    = base_val * s2_d_reg;
        n_ext = {{9{s2_n_reg[W]}}, s2_n_reg};
        n60   = n_ext * $signed((NUMW+1)'(rhsv_pkg::HUE_SLOPE));
        // never negative since |n| <= d
        num_s = $signed({1'b0, bd}) + n60;
        nh    = (NHW'(num_s[NUMW-1:0]) << (F + 1)) + NHW'(s2_d_reg);
        dm    = {s2_d_reg, {W{1'b0}}} - {{W{1'b0}}, s2_d_reg};
        ns    = NHW'({dm, 1'b0}) + NHW'(s2_max_reg);
        dzero = s2_d_reg == '0;
        // harmless divisor when the quotient is discarded
        den_h = dzero ? (W+1)'(2) : {s2_d_reg, 1'b0};
        den_s = (s2_max_reg == '0) ? (W+1)'(2) : {s2_max_reg, 1'b0};
    end

    logic           s3_valid_reg;
    logic [NHW-1:0] s3_nh_reg, s3_ns_reg;
    logic [W:0]     s3_den_h_reg, s3_den_s_reg;
    logic [W-1:0]   s3_max_reg, s3_a_reg;
    logic           s3_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_nh_reg    <= nh;
            s3_ns_reg    <= ns;
            s3_den_h_reg <= den_h;
            s3_den_s_reg <= den_s;
            s3_max_reg   <= s2_max_reg;
            s3_a_reg     <= s2_a_reg;
            s3_zero_reg  <= dzero;
        end
    end

    // ---------------- hue and saturation dividers, equal length
    logic             dh_valid;
    logic [LQW-1:0]   qh, qs;
    logic [2*W:0]     dh_side;
    logic             ds_azero;

    rhsv_div #(.QW(LQW), .DW(W+1), .SW(2*W+1)) u_div_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .num       (s3_nh_reg),
        .den       (s3_den_h_reg),
        .side      ({s3_max_reg, s3_a_reg, s3_zero_reg}),
        .out_valid (dh_valid),
        .quo       (qh),
        .side_out  (dh_side)
    );

    rhsv_div #(.QW(LQW), .DW(W+1), .SW(1)) u_div_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .num       (s3_ns_reg),
        .den       (s3_den_s_reg),
        .side      (s3_a_reg == '0),
        .out_valid (),
        .quo       (qs),
        .side_out  (ds_azero)
    );

    // ---------------- output stage: wrap, zero cases
    logic [LQW-1:0] hue_wrap;
    logic           blank;
    logic [HUE_BITS-1:0] hue_reg;
    logic [W-1:0]   sat_reg, bright_reg, alpha_reg;

    always_comb
    begin
        hue_wrap = (qh >= HUE_FULL) ? (qh - HUE_FULL) : qh;
        // grey pixel or transparent pixel has no hue or saturation
        blank    = dh_side[0] | ds_azero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dh_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg    <= blank ? '0 : hue_wrap[HUE_BITS-1:0];
            sat_reg    <= blank ? '0 : qs[W-1:0];
            bright_reg <= ds_azero ? '0 : dh_side[2*W:W+1];
            alpha_reg  <= dh_side[W:1];
        end
    end

    assign out_valid        = out_valid_reg;
    assign hue_sixtyfourths = hue_reg;
    assign sat_out          = sat_reg;
    assign brightness_out   = bright_reg;
    assign alpha_out        = alpha_reg;

endmodule
